// File: hdl/cmu_pkg.sv
// ----------------------------------------------------------------------------
// cmu_pkg
// Shared constants, types and helper functions for the cylindrical
// coordinate metric unit.
// ----------------------------------------------------------------------------
package cmu_pkg;

    localparam int CMU_ANGLE_BITS     = 16;
    localparam int CMU_FRAC_BITS      = 16;
    localparam int CMU_CORDIC_STAGES  = 16;
    localparam int CMU_ATAN_COUNT     = 24;
    localparam int CMU_XY_BITS        = 34;
    localparam int CMU_Z_BITS         = 32;
    localparam int CMU_QUO_BITS       = 33;
    localparam int CMU_RAD_BITS       = 24;
    localparam int CMU_OUT_BITS       = 32;
    localparam int CMU_LANES          = 3;

    localparam logic [31:0] CMU_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] CMU_POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] CMU_NEG_MIN  = 32'h8000_0000;
    localparam logic [CMU_QUO_BITS-1:0] CMU_POS_LIM = CMU_QUO_BITS'(64'h7FFF_FFFF);
    localparam logic [CMU_QUO_BITS-1:0] CMU_NEG_LIM = CMU_QUO_BITS'(64'h8000_0000);

    // basis direction codes
    localparam logic [1:0] DIR_RADIAL  = 2'd0;
    localparam logic [1:0] DIR_AZIMUTH = 2'd1;
    localparam logic [1:0] DIR_AXIAL   = 2'd2;

    // divider lanes
    localparam int LANE_A = 0;
    localparam int LANE_B = 1;
    localparam int LANE_C = 2;

    typedef enum logic [1:0] {
        CHR_ZERO,
        CHR_NEG_R,
        CHR_RECIP
    } cmu_chr_t;

    // item data that rides along the rotation chain
    typedef struct packed {
        logic signed [CMU_RAD_BITS-1:0] radius;
        logic signed [CMU_RAD_BITS-1:0] height;
        logic [1:0]                     direction;
        cmu_chr_t                       chr;
        logic [1:0]                     quad;
    } cmu_side_t;

    // item data that rides along the divider chain
    typedef struct packed {
        logic [CMU_OUT_BITS-1:0]        cart_x;
        logic [CMU_OUT_BITS-1:0]        cart_y;
        logic signed [CMU_RAD_BITS-1:0] radius;
        logic signed [CMU_RAD_BITS-1:0] height;
        logic [1:0]                     direction;
        cmu_chr_t                       chr;
        logic [CMU_OUT_BITS-1:0]        lb1;
        logic [CMU_OUT_BITS-1:0]        ub0;
        logic [CMU_LANES-1:0]           neg;
        logic [CMU_LANES-1:0]           ovf;
        logic [1:0]                     vpos;
        logic [1:0]                     vneg;
        logic                           zr;
    } cmu_tail_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] cmu_atan(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10680862;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // signed, saturated quotient from magnitude, sign and special flags
    function automatic logic [CMU_OUT_BITS-1:0] cmu_div_result(
        input logic [CMU_QUO_BITS-1:0] q,
        input logic                    neg,
        input logic                    ovf,
        input logic                    zr,
        input logic                    vpos,
        input logic                    vneg
    );
        logic [CMU_QUO_BITS-1:0] nq;
        logic [CMU_OUT_BITS-1:0] res;
        nq = -q;
        if (zr)
        begin
            res = vpos ? CMU_POS_MAX : (vneg ? CMU_NEG_MIN : '0);
        end
        else if (ovf)
        begin
            res = neg ? CMU_NEG_MIN : CMU_POS_MAX;
        end
        else if (neg)
        begin
            res = (q > CMU_NEG_LIM) ? CMU_NEG_MIN : nq[CMU_OUT_BITS-1:0];
        end
        else
        begin
            res = (q > CMU_POS_LIM) ? CMU_POS_MAX : q[CMU_OUT_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/cylindrical_coordinate_metric_unit.sv
// ----------------------------------------------------------------------------
// cylindrical_coordinate_metric_unit
// Cylindrical to Cartesian transform with basis vectors, Jacobian and one
// Christoffel symbol, built from a CORDIC cell chain and a divider cell chain.
// ----------------------------------------------------------------------------
// pipeline: min(CORDIC_STAGES,24) rotation cells, two preparation stages,
//   33 divider cells and the output register
// throughput: one request per cycle; the whole pipe holds while a result
//   waits at the output and the sink is not ready
// reset: rst_n clears only the stage valid bits; data registers are not reset
module cylindrical_coordinate_metric_unit
    import cmu_pkg::*;
#(
    parameter int ANGLE_BITS    = CMU_ANGLE_BITS,
    parameter int FRAC_BITS     = CMU_FRAC_BITS,
    parameter int CORDIC_STAGES = CMU_CORDIC_STAGES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // radius[23:0], angle[39:24], height[63:40], direction[65:64],
    // christoffel_i[67:66], christoffel_k[69:68], christoffel_l[71:70]
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cart_x, cart_y, cart_z, jacobian, lower_basis_0..2, upper_basis_0..2,
    // christoffel_value; 32 bits each from bit 0 up
    output logic [351:0] m_axis_tdata,
    // zero_radius
    output logic         m_axis_tuser
);

    localparam int NS   = (CORDIC_STAGES < CMU_ATAN_COUNT) ? CORDIC_STAGES : CMU_ATAN_COUNT;
    localparam int XYW  = CMU_XY_BITS;
    localparam int ZW   = CMU_Z_BITS;
    localparam int QB   = CMU_QUO_BITS;
    localparam int RW   = CMU_RAD_BITS;
    localparam int OW   = CMU_OUT_BITS;
    localparam int AW   = XYW + 1;
    localparam int PW   = RW + XYW;
    localparam int NW   = AW + FRAC_BITS + 1;
    localparam int DW   = RW + 30 - FRAC_BITS;
    localparam int CMPW = (NW > DW + QB) ? NW : DW + QB;
    localparam int LAT  = NS + 3 + QB;

    localparam logic signed [AW-1:0] QRND = AW'(64'sd1 <<< (29 - FRAC_BITS));
    localparam logic signed [PW-1:0] MRND = PW'(64'sd1 <<< 29);
    localparam logic [CMPW-1:0]      ONE_Q30 = CMPW'(64'd1 << 30);

    logic en;
    logic [LAT-1:0] valid_reg;

    assign en            = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- input unpack and angle reduction ----------------
    logic [ANGLE_BITS-1:0] ang;
    logic [31:0]           turn;
    cmu_side_t             side_in;
    logic [1:0]            ci, ck, cl;

    always_comb
    begin
        ang  = ANGLE_BITS'(s_axis_tdata[39:24]);
        turn = {ang, {(32 - ANGLE_BITS){1'b0}}} + 32'h2000_0000;
        ci   = s_axis_tdata[67:66];
        ck   = s_axis_tdata[69:68];
        cl   = s_axis_tdata[71:70];
        side_in.radius    = $signed(s_axis_tdata[23:0]);
        side_in.height    = $signed(s_axis_tdata[63:40]);
        side_in.direction = s_axis_tdata[65:64];
        side_in.quad      = turn[31:30];
        if (ci == 2'd0 && ck == 2'd1 && cl == 2'd1)
            side_in.chr = CHR_NEG_R;
        else if (ci == 2'd1 && ((ck == 2'd0 && cl == 2'd1) || (ck == 2'd1 && cl == 2'd0)))
            side_in.chr = CHR_RECIP;
        else
            side_in.chr = CHR_ZERO;
    end

    // ---------------- rotation chain ----------------
    logic signed [XYW-1:0] cx [NS+1];
    logic signed [XYW-1:0] cy [NS+1];
    logic signed [ZW-1:0]  cz [NS+1];
    cmu_side_t             side_reg [NS];

    assign cx[0] = $signed(XYW'(CMU_GAIN_Q30));
    assign cy[0] = '0;
    assign cz[0] = $signed({2'b00, turn[29:0]}) - $signed(32'h2000_0000);

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_rot
            cmu_cordic_cell #(
                .STAGE   (g),
                .XY_BITS (XYW),
                .Z_BITS  (ZW)
            ) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (cx[g]),
                .y_in  (cy[g]),
                .z_in  (cz[g]),
                .x_out (cx[g+1]),
                .y_out (cy[g+1]),
                .z_out (cz[g+1])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (g == 0)
                        side_reg[g] <= side_in;
                    else
                        side_reg[g] <= side_reg[(g == 0) ? 0 : g-1];
                end
            end
        end
    endgenerate

    // ---------------- first preparation stage ----------------
    cmu_side_t             rs;
    logic signed [AW-1:0]  cv, sv, va, vb, lsrc, usrc, lrnd, urnd, va_abs, vb_abs;
    logic signed [RW:0]    r_ext;
    logic signed [PW-1:0]  prod_x_next, prod_y_next;

    logic signed [PW-1:0]  p1_prod_x_reg, p1_prod_y_reg;
    logic [OW-1:0]         p1_lb1_reg, p1_ub0_reg;
    logic [AW-1:0]         p1_va_reg, p1_vb_reg;
    logic [RW-1:0]         p1_rabs_reg;
    logic [1:0]            p1_vpos_reg, p1_vneg_reg;
    cmu_side_t             p1_side_reg;

    always_comb
    begin
        rs = side_reg[NS-1];
        case (rs.quad)
            2'd0:
            begin
                cv = AW'(cx[NS]);
                sv = AW'(cy[NS]);
            end
            2'd1:
            begin
                cv = -AW'(cy[NS]);
                sv = AW'(cx[NS]);
            end
            2'd2:
            begin
                cv = -AW'(cx[NS]);
                sv = -AW'(cy[NS]);
            end
            default:
            begin
                cv = AW'(cy[NS]);
                sv = -AW'(cx[NS]);
            end
        endcase
        va   = (rs.direction == DIR_RADIAL) ? cv : sv;
        vb   = (rs.direction == DIR_RADIAL) ? -sv : cv;
        lsrc = (rs.direction == DIR_RADIAL) ? -sv : cv;
        usrc = (rs.direction == DIR_RADIAL) ? cv : sv;
        lrnd = (lsrc + QRND) >>> (30 - FRAC_BITS);
        urnd = (usrc + QRND) >>> (30 - FRAC_BITS);
        va_abs = va[AW-1] ? -va : va;
        vb_abs = vb[AW-1] ? -vb : vb;
        r_ext  = (RW+1)'(rs.radius);
        if (r_ext[RW])
            r_ext = -r_ext;
        prod_x_next = rs.radius * $signed(cv[XYW-1:0]);
        prod_y_next = rs.radius * $signed(sv[XYW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_prod_x_reg <= prod_x_next;
            p1_prod_y_reg <= prod_y_next;
            p1_lb1_reg    <= OW'(lrnd);
            p1_ub0_reg    <= OW'(urnd);
            p1_va_reg     <= va_abs;
            p1_vb_reg     <= vb_abs;
            p1_rabs_reg   <= r_ext[RW-1:0];
            p1_vpos_reg   <= {(vb > 0), (va > 0)};
            p1_vneg_reg   <= {vb[AW-1], va[AW-1]};
            p1_side_reg   <= rs;
        end
    end

    // ---------------- second preparation stage ----------------
    logic signed [PW-1:0]  mx, my;
    logic [CMPW-1:0]       rterm, dlim;
    logic [CMPW-1:0]       nn [CMU_LANES];
    logic [DW-1:0]         den_next;
    logic [DW-1:0]         rem0_next [CMU_LANES];
    logic [QB-1:0]         acc0_next [CMU_LANES];
    cmu_tail_t             tail_next;

    always_comb
    begin
        mx = (p1_prod_x_reg + MRND) >>> 30;
        my = (p1_prod_y_reg + MRND) >>> 30;
        den_next = DW'(p1_rabs_reg) << (30 - FRAC_BITS);
        rterm    = CMPW'(p1_rabs_reg) << (29 - FRAC_BITS);
        dlim     = CMPW'(den_next) << QB;
        nn[LANE_A] = (CMPW'(p1_va_reg) << FRAC_BITS) + rterm;
        nn[LANE_B] = (CMPW'(p1_vb_reg) << FRAC_BITS) + rterm;
        nn[LANE_C] = (ONE_Q30 << FRAC_BITS) + rterm;
        for (int k = 0; k < CMU_LANES; k++)
        begin
            rem0_next[k] = DW'(nn[k] >> QB);
            acc0_next[k] = nn[k][QB-1:0];
            tail_next.ovf[k] = (nn[k] >= dlim);
        end
        tail_next.cart_x    = OW'(mx);
        tail_next.cart_y    = OW'(my);
        tail_next.radius    = p1_side_reg.radius;
        tail_next.height    = p1_side_reg.height;
        tail_next.direction = p1_side_reg.direction;
        tail_next.chr       = p1_side_reg.chr;
        tail_next.lb1       = p1_lb1_reg;
        tail_next.ub0       = p1_ub0_reg;
        tail_next.neg[LANE_A] = p1_vneg_reg[0] ^ p1_side_reg.radius[RW-1];
        tail_next.neg[LANE_B] = p1_vneg_reg[1] ^ p1_side_reg.radius[RW-1];
        tail_next.neg[LANE_C] = p1_side_reg.radius[RW-1];
        tail_next.vpos      = p1_vpos_reg;
        tail_next.vneg      = p1_vneg_reg;
        tail_next.zr        = (p1_rabs_reg == '0);
    end

    logic [DW-1:0] den_c [QB+1];
    logic [DW-1:0] rem_c [QB+1][CMU_LANES];
    logic [QB-1:0] acc_c [QB+1][CMU_LANES];
    cmu_tail_t     tail_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_c[0]    <= den_next;
            rem_c[0]    <= rem0_next;
            acc_c[0]    <= acc0_next;
            tail_reg[0] <= tail_next;
        end
    end

    // ---------------- divider chain ----------------
    generate
        for (g = 0; g < QB; g++)
        begin : g_div
            cmu_div_cell #(
                .REM_BITS (DW),
                .QUO_BITS (QB)
            ) u_cell (
                .clk     (clk),
                .en      (en),
                .den_in  (den_c[g]),
                .rem_in  (rem_c[g]),
                .acc_in  (acc_c[g]),
                .den_out (den_c[g+1]),
                .rem_out (rem_c[g+1]),
                .acc_out (acc_c[g+1])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                    tail_reg[g+1] <= tail_reg[g];
            end
        end
    endgenerate

    // ---------------- output register ----------------
    cmu_tail_t         tq;
    logic [OW-1:0]     qa, qb, qc, lb0, lb1, lb2, ub0, ub1, ub2, chr_val, r32, h32;
    logic [351:0]      out_data_reg, out_data_next;
    logic              out_zr_reg;

    always_comb
    begin
        tq  = tail_reg[QB];
        qa  = cmu_div_result(acc_c[QB][LANE_A], tq.neg[LANE_A], tq.ovf[LANE_A], tq.zr,
                             tq.vpos[0], tq.vneg[0]);
        qb  = cmu_div_result(acc_c[QB][LANE_B], tq.neg[LANE_B], tq.ovf[LANE_B], tq.zr,
                             tq.vpos[1], tq.vneg[1]);
        qc  = cmu_div_result(acc_c[QB][LANE_C], tq.neg[LANE_C], tq.ovf[LANE_C], tq.zr,
                             1'b1, 1'b0);
        r32 = OW'(tq.radius);
        h32 = OW'(tq.height);
        lb0 = '0;
        lb1 = '0;
        lb2 = '0;
        ub0 = '0;
        ub1 = '0;
        ub2 = '0;
        case (tq.direction)
            DIR_RADIAL, DIR_AZIMUTH:
            begin
                lb0 = qa;
                lb1 = tq.lb1;
                ub0 = tq.ub0;
                ub1 = qb;
            end
            DIR_AXIAL:
            begin
                lb2 = qc;
                ub2 = OW'(1) << FRAC_BITS;
            end
            default:
            begin
                lb0 = '0;
            end
        endcase
        case (tq.chr)
            CHR_NEG_R: chr_val = -r32;
            CHR_RECIP: chr_val = qc;
            default:   chr_val = '0;
        endcase
        out_data_next = {chr_val, ub2, ub1, ub0, lb2, lb1, lb0, r32, h32,
                         tq.cart_y, tq.cart_x};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_zr_reg   <= tq.zr;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_zr_reg;

endmodule

// File: hdl/cmu_cordic_cell.sv
// ----------------------------------------------------------------------------
// cmu_cordic_cell
// One registered micro-rotation of the rotation-mode sine/cosine chain.
// ----------------------------------------------------------------------------
module cmu_cordic_cell
    import cmu_pkg::*;
#(
    parameter int STAGE   = 0,
    parameter int XY_BITS = CMU_XY_BITS,
    parameter int Z_BITS  = CMU_Z_BITS
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [XY_BITS-1:0] x_in,
    input  logic signed [XY_BITS-1:0] y_in,
    input  logic signed [Z_BITS-1:0]  z_in,
    output logic signed [XY_BITS-1:0] x_out,
    output logic signed [XY_BITS-1:0] y_out,
    output logic signed [Z_BITS-1:0]  z_out
);

    localparam logic signed [Z_BITS-1:0] ATAN = $signed(Z_BITS'(cmu_atan(STAGE)));

    logic signed [XY_BITS-1:0] x_reg, x_next;
    logic signed [XY_BITS-1:0] y_reg, y_next;
    logic signed [Z_BITS-1:0]  z_reg, z_next;
    logic signed [XY_BITS-1:0] x_sh, y_sh;

    always_comb
    begin
        x_sh = x_in >>> STAGE;
        y_sh = y_in >>> STAGE;
        if (!z_in[Z_BITS-1])
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: hdl/cmu_div_cell.sv
// ----------------------------------------------------------------------------
// cmu_div_cell
// One registered restoring-division step for three lanes sharing a divisor.
// ----------------------------------------------------------------------------
module cmu_div_cell
    import cmu_pkg::*;
#(
    parameter int REM_BITS = 38,
    parameter int QUO_BITS = CMU_QUO_BITS
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [REM_BITS-1:0] den_in,
    input  logic [REM_BITS-1:0] rem_in  [CMU_LANES],
    input  logic [QUO_BITS-1:0] acc_in  [CMU_LANES],
    output logic [REM_BITS-1:0] den_out,
    output logic [REM_BITS-1:0] rem_out [CMU_LANES],
    output logic [QUO_BITS-1:0] acc_out [CMU_LANES]
);

    logic [REM_BITS-1:0] den_reg;
    logic [REM_BITS-1:0] rem_reg  [CMU_LANES];
    logic [REM_BITS-1:0] rem_next [CMU_LANES];
    logic [QUO_BITS-1:0] acc_reg  [CMU_LANES];
    logic [QUO_BITS-1:0] acc_next [CMU_LANES];
    logic [REM_BITS:0]   trial    [CMU_LANES];
    logic [REM_BITS:0]   diff     [CMU_LANES];
    logic                fits     [CMU_LANES];

    always_comb
    begin
        for (int k = 0; k < CMU_LANES; k++)
        begin
            // bring down the next dividend bit from the top of the accumulator
            trial[k]    = {rem_in[k], acc_in[k][QUO_BITS-1]};
            diff[k]     = trial[k] - {1'b0, den_in};
            fits[k]     = (trial[k] >= {1'b0, den_in});
            rem_next[k] = fits[k] ? diff[k][REM_BITS-1:0] : trial[k][REM_BITS-1:0];
            acc_next[k] = {acc_in[k][QUO_BITS-2:0], fits[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign acc_out = acc_reg;

endmodule

// File: bench/cylindrical_coordinate_metric_unit_tb.sv
// ----------------------------------------------------------------------------
// cylindrical_coordinate_metric_unit_tb
// Streams cylindrical points through the metric unit and checks every result
// field against a bit-exact predictor of the CORDIC, product and divide path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cylindrical_coordinate_metric_unit_tb;
    import cmu_pkg::*;

    localparam int LATENCY   = 52;
    localparam int N_RANDOM  = 1880;
    localparam int HOLD_LONG = 300;

    typedef struct packed {
        logic [1:0]  cl;
        logic [1:0]  ck;
        logic [1:0]  ci;
        logic [1:0]  direction;
        logic [23:0] height;
        logic [15:0] angle;
        logic [23:0] radius;
    } point_t;

    typedef struct packed {
        logic [351:0] data;
        logic         zr;
    } metric_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [351:0] m_axis_tdata;
    logic         m_axis_tuser;

    point_t  pending_points[$];
    metric_t expected_metrics[$];
    int      errors;
    int      matched;
    int      send_gap;
    int      recv_gap;
    int      hold_left;
    bit      hold_done;
    bit      stim_done;

    cylindrical_coordinate_metric_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q30_scale(longint v);
        return clamp32(floor_shift(v + (64'sd1 <<< (29 - CMU_FRAC_BITS)), 30 - CMU_FRAC_BITS));
    endfunction

    function automatic longint radius_times(longint r, longint v);
        return clamp32(floor_shift(r * v + (64'sd1 <<< 29), 30));
    endfunction

    // rounds half away from zero
    function automatic longint over_radius(longint v, longint r);
        longint num;
        longint den;
        longint un;
        longint ud;
        longint q;
        if (r == 0)
            return v > 0 ? 64'sd2147483647 : (v < 0 ? -64'sd2147483648 : 64'sd0);
        num = v * (64'sd1 <<< CMU_FRAC_BITS);
        den = r * (64'sd1 <<< (30 - CMU_FRAC_BITS));
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = (un + ud / 2) / ud;
        return clamp32(((num < 0) != (den < 0)) ? -q : q);
    endfunction

    function automatic logic [31:0] atan_turn(int idx);
        logic [31:0] tbl [24];
        tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10680862, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215,
                2608, 1304, 652, 326, 163, 81};
        return tbl[idx];
    endfunction

    function automatic metric_t predict_metric(point_t p);
        logic [31:0] t;
        logic [1:0]  quad;
        longint      z, x, y, nx, ny, c, s, r, h;
        longint      res[11];
        metric_t     m;
        t = ({16'd0, p.angle} << (32 - CMU_ANGLE_BITS)) + 32'h2000_0000;
        quad = t[31:30];
        z = longint'({2'b00, t[29:0]}) - 64'sd536870912;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CMU_CORDIC_STAGES && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= longint'(atan_turn(i));
            end
            else
            begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += longint'(atan_turn(i));
            end
            x = nx;
            y = ny;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        r = longint'(signed'(p.radius));
        h = longint'(signed'(p.height));
        for (int j = 0; j < 11; j++)
            res[j] = 0;
        res[0] = radius_times(r, c);
        res[1] = radius_times(r, s);
        res[2] = h;
        res[3] = r;
        if (p.direction == DIR_RADIAL)
        begin
            res[4] = over_radius(c, r);
            res[5] = q30_scale(-s);
            res[7] = q30_scale(c);
            res[8] = over_radius(-s, r);
        end
        else if (p.direction == DIR_AZIMUTH)
        begin
            res[4] = over_radius(s, r);
            res[5] = q30_scale(c);
            res[7] = q30_scale(s);
            res[8] = over_radius(c, r);
        end
        else if (p.direction == DIR_AXIAL)
        begin
            res[6] = over_radius(64'sd1 <<< 30, r);
            res[9] = 64'sd1 <<< CMU_FRAC_BITS;
        end
        if (p.ci == 0 && p.ck == 1 && p.cl == 1)
            res[10] = -r;
        else if ((p.ci == 1 && p.ck == 0 && p.cl == 1) || (p.ci == 1 && p.ck == 1 && p.cl == 0))
            res[10] = over_radius(64'sd1 <<< 30, r);
        for (int j = 0; j < 11; j++)
            m.data[j*32 +: 32] = res[j][31:0];
        m.zr = (r == 0);
        return m;
    endfunction

    function automatic point_t random_point();
        point_t p;
        int     sel;
        p = point_t'(72'({$urandom, $urandom, $urandom}));
        sel = $urandom_range(0, 9);
        if (sel == 0)
            p.radius = 24'd0;
        else if (sel == 1)
            p.radius = 24'($signed($urandom_range(0, 64)) - 32);
        else if (sel == 2)
            p.radius = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        // mostly valid codes, some three
        if ($urandom_range(0, 7) != 0)
            p.direction = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0)
        begin
            p.ci = 2'($urandom_range(0, 1));
            p.ck = 2'($urandom_range(0, 1));
            p.cl = 2'($urandom_range(0, 1));
        end
        return p;
    endfunction

    initial
    begin
        point_t p;
        logic [23:0] radii [6];
        logic [15:0] angles [6];
        radii  = '{24'h7FFFFF, 24'h800000, 24'd0, 24'd1, 24'hFFFFFF, 24'h010000};
        angles = '{16'd0, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
        for (int i = 0; i < 24; i++)
        begin
            p.radius    = radii[i % 6];
            p.angle     = angles[(i / 2) % 6];
            p.height    = (i % 3 == 0) ? 24'h7FFFFF : ((i % 3 == 1) ? 24'h800000 : 24'd0);
            p.direction = 2'(i % 4);
            p.ci        = 2'((i / 4) % 4);
            p.ck        = 2'((i % 2) ? 1 : (i / 8) % 4);
            p.cl        = 2'((i % 3 == 0) ? 0 : 1);
            pending_points.push_back(p);
        end
        for (int i = 0; i < N_RANDOM; i++)
            pending_points.push_back(random_point());
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
            stim_done     <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_metrics.push_back(predict_metric(point_t'(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    p = pending_points.pop_front();
                    s_axis_tdata  <= p;
                    s_axis_tvalid <= 1'b1;
                    send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    stim_done     <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        metric_t want;
        int      bad;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
            errors        <= 0;
            matched       <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                bad = 0;
                if (expected_metrics.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    bad = bad + 1;
                end
                else
                begin
                    want = expected_metrics.pop_front();
                    for (int j = 0; j < 11; j++)
                        if (want.data[j*32 +: 32] !== m_axis_tdata[j*32 +: 32])
                        begin
                            $display("%0t: field %0d expected %h actual %h", $time, j,
                                     want.data[j*32 +: 32], m_axis_tdata[j*32 +: 32]);
                            bad = bad + 1;
                        end
                    if (want.zr !== m_axis_tuser)
                    begin
                        $display("%0t: zero_radius expected %b actual %b", $time,
                                 want.zr, m_axis_tuser);
                        bad = bad + 1;
                    end
                    matched <= matched + 1;
                end
                errors <= errors + bad;
            end
            // one long hold-off so the pipe backs up into the input
            if (!hold_done && matched == 400)
            begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_LONG;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (recv_gap > 0)
            begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait (stim_done && expected_metrics.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        $display("covered %0d points: radius extremes and zero, all quadrants,", matched);
        $display("every direction and index code, with random stalls on both sides");
        if (errors == 0 && expected_metrics.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/cmu_pkg.sv
hdl/cmu_cordic_cell.sv
hdl/cmu_div_cell.sv
hdl/cylindrical_coordinate_metric_unit.sv
bench/cylindrical_coordinate_metric_unit_tb.sv
